// File: rtl/core/ben_pkg.sv
// ---------------------------------------------------------------------------
// ben_pkg: shared types and constants for the bully election node
// Message kinds, node modes, sequencer states and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package ben_pkg;

  localparam int NODES_DEF = 8;
  localparam int TMO_MAX   = 255;

  // message kinds (3 bit wire codes)
  localparam logic [2:0] K_ELECT  = 3'd0;
  localparam logic [2:0] K_ANSWER = 3'd1;
  localparam logic [2:0] K_COORD  = 3'd2;
  localparam logic [2:0] K_AYA    = 3'd3;
  localparam logic [2:0] K_IAA    = 3'd4;
  localparam logic [2:0] K_NONE   = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_ID     = 2'd0;
  localparam logic [1:0] CFG_MEMBERS    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;
  localparam logic [1:0] CFG_INIT_COORD = 2'd3;

  // register reset values
  localparam logic [2:0] RST_OWN_ID     = 3'd0;
  localparam logic [7:0] RST_MEMBERS    = 8'hff;
  localparam logic [7:0] RST_TIMEOUT    = 8'd5;
  localparam logic [2:0] RST_INIT_COORD = 3'd7;

  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_AYA     = 3'd1,
    M_ELECT   = 3'd2,
    M_AWANS   = 3'd3,
    M_AWCOORD = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_CMP,
    S_DECIDE,
    S_PRE,
    S_SCAN,
    S_STATUS
  } seq_t;

endpackage

`default_nettype wire

// File: rtl/core/ben_if.sv
// ---------------------------------------------------------------------------
// ben_if: request and result channels of the election node
// Valid/ready channels; the source drives valid and payload, the sink ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface ben_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [2:0]  msg_kind;
  logic [2:0]  sender_id;
  logic [15:0] msg_election_id;
  logic [7:0]  aya_wait;

  modport source (output valid, operation, msg_kind, sender_id, msg_election_id,
                  aya_wait, input ready);
  modport sink (input valid, operation, msg_kind, sender_id, msg_election_id,
                aya_wait, output ready);
endinterface

interface ben_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [2:0]  dest_id;
  logic [2:0]  send_kind;
  logic [15:0] send_election_id;
  logic [2:0]  node_mode;
  logic [2:0]  coordinator_id;
  logic        last_result;

  modport source (output valid, send_valid, dest_id, send_kind, send_election_id,
                  node_mode, coordinator_id, last_result, input ready);
  modport sink (input valid, send_valid, dest_id, send_kind, send_election_id,
                node_mode, coordinator_id, last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bully_election_node_fsm_unit.sv
// ---------------------------------------------------------------------------
// bully_election_node_fsm_unit: one node of a bully leader election
// Heartbeat polling, election and coordinator announcement, one request
// at a time, with results sent one per cycle through an output register while the sink is ready.
// ---------------------------------------------------------------------------
// Sequence: a taken request passes the difference and compare steps of the
//   shared timeout unit and the decide step, then the send slot, any member
//   scan and the status item; a new request is taken only after the status
//   item is loaded. A member scan covers min(NODES,8) member ids, one member
//   id per cycle while the output is not stalled.
// Reset: synchronous, active low; state, configuration and control registers
//   take their reset values with no clearing pass; payload registers are not reset.
`default_nettype none

module bully_election_node_fsm_unit #(
  parameter int NODES = ben_pkg::NODES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  ben_in_if.sink          in_req,
  ben_out_if.source       out_res,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int SCAN_N    = (NODES < 8) ? NODES : 8;
  localparam int AWC_MULT  = NODES + 1;
  localparam int LIMIT_W   = $clog2(ben_pkg::TMO_MAX * AWC_MULT + 1);
  localparam logic [2:0] SCAN_LAST = 3'(SCAN_N - 1);

  // configuration
  logic [2:0] own_r;
  logic [7:0] members_r;
  logic [7:0] tmo_r;

  // node state
  ben_pkg::mode_t mode_r, mode_nxt;
  logic [2:0]  coord_r, coord_nxt;
  logic [15:0] ecnt_r, ecnt_nxt;
  logic [31:0] secs_r;
  logic [31:0] last_iaa_r, last_iaa_nxt;
  logic [31:0] last_aya_r, last_aya_nxt;
  logic [31:0] elect_start_r, elect_start_nxt;
  logic [31:0] awc_start_r, awc_start_nxt;
  logic [7:0]  hb_wait_r, hb_wait_nxt;

  // latched request
  logic [2:0]  kind_r;
  logic [2:0]  from_r;
  logic [15:0] eid_r;
  logic [7:0]  wait_r;

  // sequencer and send plan
  ben_pkg::seq_t seq_r, seq_nxt;
  logic        pre_v_r, pre_v_nxt;
  logic [2:0]  pre_dest_r, pre_dest_nxt;
  logic [2:0]  pre_kind_r, pre_kind_nxt;
  logic [15:0] pre_eid_r, pre_eid_nxt;
  logic        scan_en_r, scan_en_nxt;
  logic        scan_hi_r, scan_hi_nxt;
  logic [2:0]  scan_idx_r, scan_idx_nxt;

  // output register
  logic        out_valid_r;
  logic        o_send_r, o_last_r;
  logic [2:0]  o_dest_r, o_kind_r, o_mode_r, o_coord_r;
  logic [15:0] o_eid_r;

  logic        accept;
  logic        want_emit, out_load, out_free;
  logic        em_send, em_last;
  logic [2:0]  em_dest, em_kind;
  logic [15:0] em_eid;
  logic        scan_hit;
  logic        go_normal;
  logic [2:0]  coord_tmp;

  logic [31:0]        t_since;
  logic [LIMIT_W-1:0] t_limit;
  logic               expired;

  assign accept       = in_req.valid && in_req.ready;
  assign in_req.ready = (seq_r == ben_pkg::S_IDLE);
  assign out_free     = !out_valid_r || out_res.ready;
  assign out_load     = want_emit && out_free;

  // timeout source by mode
  always_comb begin
    case (mode_r)
      ben_pkg::M_NORMAL: begin
        t_since = last_iaa_r;
        t_limit = LIMIT_W'(hb_wait_r);
      end
      ben_pkg::M_AYA: begin
        t_since = last_aya_r;
        t_limit = LIMIT_W'(tmo_r);
      end
      ben_pkg::M_AWANS: begin
        t_since = elect_start_r;
        t_limit = LIMIT_W'(tmo_r);
      end
      ben_pkg::M_AWCOORD: begin
        t_since = awc_start_r;
        t_limit = LIMIT_W'(tmo_r) * LIMIT_W'(AWC_MULT);
      end
      default: begin
        t_since = secs_r;
        t_limit = '0;
      end
    endcase
  end

  ben_elapsed #(
    .LIMIT_W (LIMIT_W)
  ) u_elapsed (
    .clk     (clk),
    .load    (seq_r == ben_pkg::S_DIFF),
    .now     (secs_r),
    .since   (t_since),
    .limit   (t_limit),
    .expired (expired)
  );

  assign scan_hit = members_r[scan_idx_r] &&
                    (scan_hi_r ? (scan_idx_r > own_r) : (scan_idx_r < own_r));

  always_comb begin
    seq_nxt         = seq_r;
    mode_nxt        = mode_r;
    coord_nxt       = coord_r;
    ecnt_nxt        = ecnt_r;
    last_iaa_nxt    = last_iaa_r;
    last_aya_nxt    = last_aya_r;
    elect_start_nxt = elect_start_r;
    awc_start_nxt   = awc_start_r;
    hb_wait_nxt     = hb_wait_r;
    pre_v_nxt       = pre_v_r;
    pre_dest_nxt    = pre_dest_r;
    pre_kind_nxt    = pre_kind_r;
    pre_eid_nxt     = pre_eid_r;
    scan_en_nxt     = scan_en_r;
    scan_hi_nxt     = scan_hi_r;
    scan_idx_nxt    = scan_idx_r;
    want_emit       = 1'b0;
    em_send         = 1'b0;
    em_last         = 1'b0;
    em_dest         = '0;
    em_kind         = '0;
    em_eid          = '0;
    go_normal       = 1'b0;
    coord_tmp       = coord_r;

    case (seq_r)
      ben_pkg::S_IDLE: begin
        if (accept) seq_nxt = ben_pkg::S_DIFF;
      end
      ben_pkg::S_DIFF: seq_nxt = ben_pkg::S_CMP;
      ben_pkg::S_CMP:  seq_nxt = ben_pkg::S_DECIDE;
      ben_pkg::S_DECIDE: begin
        pre_v_nxt    = 1'b0;
        pre_dest_nxt = from_r;
        pre_kind_nxt = ben_pkg::K_ANSWER;
        pre_eid_nxt  = eid_r;
        scan_en_nxt  = 1'b0;
        scan_hi_nxt  = 1'b0;
        scan_idx_nxt = '0;
        seq_nxt      = ben_pkg::S_PRE;
        case (mode_r)
          ben_pkg::M_NORMAL: begin
            if (kind_r == ben_pkg::K_ELECT) begin
              pre_v_nxt = 1'b1;
              ecnt_nxt  = ecnt_r + 16'd1;
              mode_nxt  = ben_pkg::M_ELECT;
            end else begin
              if (kind_r == ben_pkg::K_COORD) coord_tmp = from_r;
              coord_nxt = coord_tmp;
              if (kind_r == ben_pkg::K_AYA && coord_r == own_r) begin
                pre_v_nxt    = 1'b1;
                pre_kind_nxt = ben_pkg::K_IAA;
              end
              // IAA reply needs us as coordinator, the poll needs the opposite
              if (coord_tmp != own_r && expired) begin
                pre_v_nxt    = 1'b1;
                pre_dest_nxt = coord_tmp;
                pre_kind_nxt = ben_pkg::K_AYA;
                pre_eid_nxt  = 16'(own_r);
                last_aya_nxt = secs_r;
                mode_nxt     = ben_pkg::M_AYA;
              end
            end
          end
          ben_pkg::M_AYA: begin
            if (kind_r == ben_pkg::K_ELECT) begin
              pre_v_nxt = 1'b1;
              ecnt_nxt  = ecnt_r + 16'd1;
              mode_nxt  = ben_pkg::M_ELECT;
            end else if (kind_r == ben_pkg::K_COORD) begin
              coord_nxt = from_r;
              go_normal = 1'b1;
            end else if (kind_r == ben_pkg::K_IAA) begin
              go_normal = 1'b1;
            end else if (expired) begin
              ecnt_nxt = ecnt_r + 16'd1;
              mode_nxt = ben_pkg::M_ELECT;
            end
          end
          ben_pkg::M_ELECT: begin
            if (kind_r == ben_pkg::K_COORD) begin
              coord_nxt = from_r;
              go_normal = 1'b1;
            end else begin
              pre_v_nxt       = (kind_r == ben_pkg::K_ELECT);
              scan_en_nxt     = 1'b1;
              scan_hi_nxt     = 1'b1;
              elect_start_nxt = secs_r;
              mode_nxt        = ben_pkg::M_AWANS;
            end
          end
          ben_pkg::M_AWANS: begin
            if (kind_r == ben_pkg::K_COORD) begin
              coord_nxt = from_r;
              go_normal = 1'b1;
            end else if (kind_r == ben_pkg::K_ANSWER) begin
              awc_start_nxt = secs_r;
              mode_nxt      = ben_pkg::M_AWCOORD;
            end else begin
              pre_v_nxt = (kind_r == ben_pkg::K_ELECT);
              if (expired) begin
                scan_en_nxt = 1'b1;
                coord_nxt   = own_r;
                mode_nxt    = ben_pkg::M_NORMAL;
              end
            end
          end
          ben_pkg::M_AWCOORD: begin
            if (kind_r == ben_pkg::K_COORD) begin
              coord_nxt = from_r;
              go_normal = 1'b1;
            end else begin
              pre_v_nxt = (kind_r == ben_pkg::K_ELECT);
              if (expired) begin
                ecnt_nxt = ecnt_r + 16'd1;
                mode_nxt = ben_pkg::M_ELECT;
              end
            end
          end
          default: ;
        endcase
        if (go_normal) begin
          last_iaa_nxt = secs_r;
          hb_wait_nxt  = wait_r;
          mode_nxt     = ben_pkg::M_NORMAL;
        end
      end
      ben_pkg::S_PRE: begin
        want_emit = pre_v_r;
        em_send   = 1'b1;
        em_dest   = pre_dest_r;
        em_kind   = pre_kind_r;
        em_eid    = pre_eid_r;
        if (!pre_v_r || out_free)
          seq_nxt = scan_en_r ? ben_pkg::S_SCAN : ben_pkg::S_STATUS;
      end
      ben_pkg::S_SCAN: begin
        want_emit = scan_hit;
        em_send   = 1'b1;
        em_dest   = scan_idx_r;
        em_kind   = scan_hi_r ? ben_pkg::K_ELECT : ben_pkg::K_COORD;
        em_eid    = ecnt_r;
        if (!scan_hit || out_free) begin
          if (scan_idx_r == SCAN_LAST) begin
            scan_idx_nxt = '0;
            seq_nxt      = ben_pkg::S_STATUS;
          end else begin
            scan_idx_nxt = scan_idx_r + 3'd1;
          end
        end
      end
      ben_pkg::S_STATUS: begin
        want_emit = 1'b1;
        em_last   = 1'b1;
        if (out_free) seq_nxt = ben_pkg::S_IDLE;
      end
      default: seq_nxt = ben_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r         <= ben_pkg::S_IDLE;
      mode_r        <= ben_pkg::M_NORMAL;
      coord_r       <= ben_pkg::RST_INIT_COORD;
      ecnt_r        <= '0;
      secs_r        <= '0;
      last_iaa_r    <= '0;
      last_aya_r    <= '0;
      elect_start_r <= '0;
      awc_start_r   <= '0;
      hb_wait_r     <= '0;
      own_r         <= ben_pkg::RST_OWN_ID;
      members_r     <= ben_pkg::RST_MEMBERS;
      tmo_r         <= ben_pkg::RST_TIMEOUT;
      out_valid_r   <= 1'b0;
      pre_v_r       <= 1'b0;
      scan_en_r     <= 1'b0;
      scan_idx_r    <= '0;
    end else begin
      seq_r         <= seq_nxt;
      mode_r        <= mode_nxt;
      coord_r       <= coord_nxt;
      ecnt_r        <= ecnt_nxt;
      last_iaa_r    <= last_iaa_nxt;
      last_aya_r    <= last_aya_nxt;
      elect_start_r <= elect_start_nxt;
      awc_start_r   <= awc_start_nxt;
      hb_wait_r     <= hb_wait_nxt;
      pre_v_r       <= pre_v_nxt;
      scan_en_r     <= scan_en_nxt;
      scan_idx_r    <= scan_idx_nxt;
      if (accept && !in_req.operation) secs_r <= secs_r + 32'd1;
      if (out_load)           out_valid_r <= 1'b1;
      else if (out_res.ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          ben_pkg::CFG_OWN_ID:     own_r     <= cfg_data[2:0];
          ben_pkg::CFG_MEMBERS:    members_r <= cfg_data;
          ben_pkg::CFG_TIMEOUT:    tmo_r     <= cfg_data;
          // initial coordinator only matters at reset, which restores it
          ben_pkg::CFG_INIT_COORD: ;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_req.operation ? in_req.msg_kind : ben_pkg::K_NONE;
      from_r <= in_req.sender_id;
      eid_r  <= in_req.msg_election_id;
      wait_r <= in_req.aya_wait;
    end
    pre_dest_r <= pre_dest_nxt;
    pre_kind_r <= pre_kind_nxt;
    pre_eid_r  <= pre_eid_nxt;
    scan_hi_r  <= scan_hi_nxt;
    if (out_load) begin
      o_send_r  <= em_send;
      o_last_r  <= em_last;
      o_dest_r  <= em_dest;
      o_kind_r  <= em_kind;
      o_eid_r   <= em_eid;
      o_mode_r  <= 3'(mode_r);
      o_coord_r <= coord_r;
    end
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.send_valid       = o_send_r;
  assign out_res.dest_id          = o_dest_r;
  assign out_res.send_kind        = o_kind_r;
  assign out_res.send_election_id = o_eid_r;
  assign out_res.node_mode        = o_mode_r;
  assign out_res.coordinator_id   = o_coord_r;
  assign out_res.last_result      = o_last_r;

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_req.ready)
    else $error("request taken while a request is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_load && out_valid_r && !out_res.ready))
    else $error("pending result overwritten");

  a_status_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_last_r |-> !o_send_r)
    else $error("status item marked as send");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == ben_pkg::S_SCAN |-> scan_idx_r <= SCAN_LAST)
    else $error("member scan out of range");

endmodule

`default_nettype wire

// File: rtl/core/ben_elapsed.sv
// ---------------------------------------------------------------------------
// ben_elapsed: shared timeout unit
// Subtracts a timestamp from the seconds clock, then compares to a limit.
// ---------------------------------------------------------------------------
`default_nettype none

module ben_elapsed #(
  parameter int LIMIT_W = 12
) (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic [31:0]        now,
  input  wire logic [31:0]        since,
  input  wire logic [LIMIT_W-1:0] limit,
  output logic                    expired
);

  logic [31:0]        diff_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               expired_r;

  // stage 1 on load: modulo 2^32 difference; stage 2 next cycle: compare
  always_ff @(posedge clk) begin
    if (load) begin
      diff_r  <= now - since;
      limit_r <= limit;
    end
    expired_r <= diff_r > 32'(limit_r);
  end

  assign expired = expired_r;

endmodule

`default_nettype wire
